/* hdl/sdh_pkg.sv */
// shared types and constants for the substring double hash unit
package sdh_pkg;

   localparam int unsigned MAX_LENGTH_DEF = 4096;
   localparam int unsigned HALF_W = 30;
   localparam int unsigned PAIR_W = 2 * HALF_W;
   localparam int unsigned POS_W = 12;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned STORED_W = 13;
   localparam int unsigned STATUS_W = 2;

   localparam logic [HALF_W-1:0] MOD_FIRST = 30'd1000015553;
   localparam logic [HALF_W-1:0] MOD_SECOND = 30'd1000028537;
   localparam logic [HALF_W-1:0] BASE_RESET = 30'd356;

   // barrett factors, floor(2^60 / modulus)
   localparam logic [HALF_W:0] MU_FIRST = 31'((64'd1 << 60) / 64'(MOD_FIRST));
   localparam logic [HALF_W:0] MU_SECOND = 31'((64'd1 << 60) / 64'(MOD_SECOND));

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic              command;
      logic              start_new;
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  right;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAIR_W-1:0]   hash_value;
      logic [STORED_W-1:0] stored_length;
   } rsp_type;

   typedef enum logic [1:0] {
      MM_POW,
      MM_HASH,
      MM_QRY
   } mm_tag_type;

   typedef struct packed {
      logic              valid;
      mm_tag_type        tag;
      logic [HALF_W-1:0] a_first;
      logic [HALF_W-1:0] b_first;
      logic [HALF_W-1:0] a_second;
      logic [HALF_W-1:0] b_second;
      logic [CHAR_W-1:0] addend;
   } mm_req_type;

   typedef struct packed {
      logic              valid;
      mm_tag_type        tag;
      logic [HALF_W-1:0] res_first;
      logic [HALF_W-1:0] res_second;
   } mm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APP_POW,
      ST_APP_HASH,
      ST_APP_WAIT,
      ST_QRY_DIRECT,
      ST_QRY_ISSUE,
      ST_QRY_WAIT
   } state_type;

endpackage

/* hdl/sdh_store.sv */
// simple dual port pair store, one write and one registered read port, holding both moduli values of one position
module sdh_store #(
   parameter int unsigned DEPTH = sdh_pkg::MAX_LENGTH_DEF,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [sdh_pkg::PAIR_W-1:0] wdata,
   input  logic                       re,
   input  logic [AW-1:0]              raddr,
   output logic [sdh_pkg::PAIR_W-1:0] rdata
);

   logic [sdh_pkg::PAIR_W-1:0] store_mem [DEPTH];
   logic [sdh_pkg::PAIR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/sdh_mulmod.sv */
// four stage a*b+c mod both primes, barrett reduction per lane
module sdh_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  sdh_pkg::mm_req_type mm_req,
   output sdh_pkg::mm_rsp_type mm_rsp
);

   localparam int unsigned STAGES = 4;
   localparam int unsigned HW = sdh_pkg::HALF_W;
   localparam int unsigned XW = 2 * HW;
   localparam int unsigned QW = 2 * (HW + 1);

   logic [STAGES-1:0]   vld_ff;
   logic [STAGES-1:0]   vld_in;
   sdh_pkg::mm_tag_type tag_ff [STAGES];

   logic [HW-1:0] op_a [2];
   logic [HW-1:0] op_b [2];
   logic [XW-1:0] x_ff [2];
   logic [XW-1:0] x_in [2];
   logic [QW-1:0] q2_ff [2];
   logic [QW-1:0] q2_in [2];
   logic [31:0]   xl_ff [2];
   logic [31:0]   r_ff [2];
   logic [31:0]   r_in [2];
   logic [HW-1:0] res_ff [2];
   logic [HW-1:0] res_in [2];

   assign op_a[0] = mm_req.a_first;
   assign op_b[0] = mm_req.b_first;
   assign op_a[1] = mm_req.a_second;
   assign op_b[1] = mm_req.b_second;

   assign vld_in = {vld_ff[STAGES-2:0], mm_req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= mm_req.tag;
      for (int i = 1; i < STAGES; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      localparam logic [HW-1:0] M = (g == 0) ? sdh_pkg::MOD_FIRST : sdh_pkg::MOD_SECOND;
      localparam logic [HW:0] MU = (g == 0) ? sdh_pkg::MU_FIRST : sdh_pkg::MU_SECOND;
      localparam logic [31:0] M_X1 = 32'(M);
      localparam logic [31:0] M_X2 = M_X1 << 1;

      assign x_in[g] = (XW'(op_a[g]) * XW'(op_b[g])) + XW'(mm_req.addend);
      assign q2_in[g] = QW'(x_ff[g][XW-1:HW-1]) * QW'(MU);
      assign r_in[g] = xl_ff[g] - (32'(q2_ff[g][QW-1:HW+1]) * M_X1);

      always_comb begin
         if (r_ff[g] >= M_X2) begin
            res_in[g] = HW'(r_ff[g] - M_X2);
         end else if (r_ff[g] >= M_X1) begin
            res_in[g] = HW'(r_ff[g] - M_X1);
         end else begin
            res_in[g] = HW'(r_ff[g]);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[g] <= x_in[g];
         q2_ff[g] <= q2_in[g];
         xl_ff[g] <= x_ff[g][31:0];
         r_ff[g] <= r_in[g];
         res_ff[g] <= res_in[g];
      end
   end

   assign mm_rsp.valid = vld_ff[STAGES-1];
   assign mm_rsp.tag = tag_ff[STAGES-1];
   assign mm_rsp.res_first = res_ff[0];
   assign mm_rsp.res_second = res_ff[1];

endmodule

/* hdl/substring_double_hash_unit.sv */
// top level: double modulus rolling hash over a stored byte string
// invalid query, full append and first byte append answer in the cycle after start;
//    left zero query: QRY_DIRECT, other query: QRY_ISSUE/WAIT, append: APP_POW/HASH/WAIT
// throughput: next transaction taken in the cycle its predecessor answers, since busy
//    covers the store reads and the four stage barrett multiply-reduce pipeline
// reset: synchronous, clears length, control and base (356); stores are not cleared
// results are strobed for one cycle and the receiver cannot stall
module substring_double_hash_unit #(
   parameter int unsigned MAX_LENGTH = sdh_pkg::MAX_LENGTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sdh_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output sdh_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [sdh_pkg::HALF_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_LENGTH);
   localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
   localparam int unsigned CMP_W = (LEN_W > sdh_pkg::POS_W) ? LEN_W : sdh_pkg::POS_W;
   localparam int unsigned HW = sdh_pkg::HALF_W;
   localparam int unsigned SW = sdh_pkg::STORED_W;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   function automatic logic [HW-1:0] mod_sub(input logic [HW-1:0] h, input logic [HW-1:0] t,
                                             input logic [HW-1:0] m);
      mod_sub = (h >= t) ? (h - t) : (h - t + m);
   endfunction

   sdh_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [HW-1:0]      base_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      right_ff, right_in;
   logic [7:0]         char_ff, char_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sdh_pkg::rsp_type   rsp_ff, rsp_in;

   logic accept, is_app, app_full, app_first, app_long;
   logic qry_bad, qry_direct, qry_long;
   logic mm_pow_hit, mm_hash_hit, mm_qry_hit;
   logic [LEN_W-1:0] n_acc;

   logic                       hash_we, hash_re, pow_we, pow_re;
   logic [AW-1:0]              hash_waddr, hash_raddr, pow_waddr, pow_raddr;
   logic [sdh_pkg::PAIR_W-1:0] hash_wdata, hash_rdata, pow_wdata, pow_rdata;

   sdh_pkg::mm_req_type mm_req;
   sdh_pkg::mm_rsp_type mm_rsp;

   sdh_store #(.DEPTH(MAX_LENGTH)) u_hash_store (
      .clock(clock),
      .we   (hash_we),
      .waddr(hash_waddr),
      .wdata(hash_wdata),
      .re   (hash_re),
      .raddr(hash_raddr),
      .rdata(hash_rdata)
   );

   sdh_store #(.DEPTH(MAX_LENGTH)) u_pow_store (
      .clock(clock),
      .we   (pow_we),
      .waddr(pow_waddr),
      .wdata(pow_wdata),
      .re   (pow_re),
      .raddr(pow_raddr),
      .rdata(pow_rdata)
   );

   sdh_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .mm_req(mm_req),
      .mm_rsp(mm_rsp)
   );

   assign busy = (state_ff != sdh_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign is_app = (req_data.command == sdh_pkg::CMD_APPEND);
   assign n_acc = req_data.start_new ? '0 : len_ff;
   assign app_full = (n_acc >= LEN_MAX);
   assign app_first = (n_acc == '0);
   assign app_long = is_app && !app_full && !app_first;
   assign qry_bad = (req_data.left > req_data.right) ||
                    (CMP_W'(req_data.right) >= CMP_W'(len_ff));
   assign qry_direct = !is_app && !qry_bad && (req_data.left == '0);
   assign qry_long = !is_app && !qry_bad && (req_data.left != '0);

   assign mm_pow_hit = mm_rsp.valid && (mm_rsp.tag == sdh_pkg::MM_POW);
   assign mm_hash_hit = mm_rsp.valid && (mm_rsp.tag == sdh_pkg::MM_HASH);
   assign mm_qry_hit = mm_rsp.valid && (mm_rsp.tag == sdh_pkg::MM_QRY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdh_pkg::ST_IDLE: begin
            if (accept && app_long) begin
               state_in = sdh_pkg::ST_APP_POW;
            end else if (accept && qry_direct) begin
               state_in = sdh_pkg::ST_QRY_DIRECT;
            end else if (accept && qry_long) begin
               state_in = sdh_pkg::ST_QRY_ISSUE;
            end
         end
         sdh_pkg::ST_APP_POW: state_in = sdh_pkg::ST_APP_HASH;
         sdh_pkg::ST_APP_HASH: state_in = sdh_pkg::ST_APP_WAIT;
         sdh_pkg::ST_APP_WAIT: begin
            if (mm_hash_hit) begin
               state_in = sdh_pkg::ST_IDLE;
            end
         end
         sdh_pkg::ST_QRY_DIRECT: state_in = sdh_pkg::ST_IDLE;
         sdh_pkg::ST_QRY_ISSUE: state_in = sdh_pkg::ST_QRY_WAIT;
         sdh_pkg::ST_QRY_WAIT: begin
            if (mm_qry_hit) begin
               state_in = sdh_pkg::ST_IDLE;
            end
         end
         default: state_in = sdh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      len_in = len_ff;
      addr_in = addr_ff;
      right_in = right_ff;
      char_in = char_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      rsp_in.stored_length = SW'(len_ff);
      hash_we = 1'b0;
      hash_waddr = addr_ff;
      hash_wdata = {mm_rsp.res_first, mm_rsp.res_second};
      hash_re = 1'b0;
      hash_raddr = '0;
      pow_we = 1'b0;
      pow_waddr = addr_ff;
      pow_wdata = {mm_rsp.res_first, mm_rsp.res_second};
      pow_re = 1'b0;
      pow_raddr = '0;
      mm_req = '0;

      unique case (state_ff)
         sdh_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in = AW'(n_acc);
               right_in = AW'(req_data.right);
               char_in = req_data.char_code;
               if (is_app) begin
                  if (app_full) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = sdh_pkg::STATUS_FULL;
                  end else if (app_first) begin
                     pow_we = 1'b1;
                     pow_waddr = '0;
                     pow_wdata = {HW'(1), HW'(1)};
                     hash_we = 1'b1;
                     hash_waddr = '0;
                     hash_wdata = {HW'(req_data.char_code), HW'(req_data.char_code)};
                     len_in = LEN_ONE;
                     rsp_valid_in = 1'b1;
                     rsp_in.status = sdh_pkg::STATUS_OK;
                     rsp_in.stored_length = SW'(LEN_ONE);
                  end else begin
                     hash_re = 1'b1;
                     pow_re = 1'b1;
                     hash_raddr = AW'(n_acc - LEN_ONE);
                     pow_raddr = AW'(n_acc - LEN_ONE);
                  end
               end else begin
                  if (qry_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = sdh_pkg::STATUS_BAD_RANGE;
                  end else if (qry_direct) begin
                     hash_re = 1'b1;
                     hash_raddr = AW'(req_data.right);
                  end else begin
                     hash_re = 1'b1;
                     hash_raddr = AW'(req_data.left - 12'd1);
                     pow_re = 1'b1;
                     pow_raddr = AW'(req_data.right - req_data.left + 12'd1);
                  end
               end
            end
         end
         sdh_pkg::ST_APP_POW: begin
            mm_req.valid = 1'b1;
            mm_req.tag = sdh_pkg::MM_POW;
            mm_req.a_first = pow_rdata[2*HW-1:HW];
            mm_req.a_second = pow_rdata[HW-1:0];
            mm_req.b_first = base_ff;
            mm_req.b_second = base_ff;
         end
         sdh_pkg::ST_APP_HASH: begin
            mm_req.valid = 1'b1;
            mm_req.tag = sdh_pkg::MM_HASH;
            mm_req.a_first = hash_rdata[2*HW-1:HW];
            mm_req.a_second = hash_rdata[HW-1:0];
            mm_req.b_first = base_ff;
            mm_req.b_second = base_ff;
            mm_req.addend = char_ff;
         end
         sdh_pkg::ST_APP_WAIT: begin
            if (mm_hash_hit) begin
               hash_we = 1'b1;
               len_in = len_ff + LEN_ONE;
               rsp_valid_in = 1'b1;
               rsp_in.status = sdh_pkg::STATUS_OK;
               rsp_in.stored_length = SW'(len_ff + LEN_ONE);
            end
         end
         sdh_pkg::ST_QRY_DIRECT: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = sdh_pkg::STATUS_OK;
            rsp_in.hash_value = hash_rdata;
         end
         sdh_pkg::ST_QRY_ISSUE: begin
            mm_req.valid = 1'b1;
            mm_req.tag = sdh_pkg::MM_QRY;
            mm_req.a_first = hash_rdata[2*HW-1:HW];
            mm_req.a_second = hash_rdata[HW-1:0];
            mm_req.b_first = pow_rdata[2*HW-1:HW];
            mm_req.b_second = pow_rdata[HW-1:0];
            hash_re = 1'b1;
            hash_raddr = right_ff;
         end
         sdh_pkg::ST_QRY_WAIT: begin
            if (mm_qry_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = sdh_pkg::STATUS_OK;
               rsp_in.hash_value = {
                  mod_sub(hash_rdata[2*HW-1:HW], mm_rsp.res_first, sdh_pkg::MOD_FIRST),
                  mod_sub(hash_rdata[HW-1:0], mm_rsp.res_second, sdh_pkg::MOD_SECOND)
               };
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      // power entries land while the hash step is still in flight
      if (mm_pow_hit) begin
         pow_we = 1'b1;
         pow_waddr = addr_ff;
         pow_wdata = {mm_rsp.res_first, mm_rsp.res_second};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdh_pkg::ST_IDLE;
         len_ff <= '0;
         base_ff <= sdh_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      right_ff <= right_in;
      char_ff <= char_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* hdl/sdh_checker.sv */
// port level checks for the substring double hash unit, bound to the top level
module sdh_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sdh_pkg::req_type req_data,
   input logic             rsp_valid,
   input sdh_pkg::rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("response or busy right after reset");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !start && !busy |=> !rsp_valid)
      else $error("response without a transaction in flight");

   a_error_zero_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != sdh_pkg::STATUS_OK |-> rsp_data.hash_value == '0)
      else $error("nonzero hash on a rejected transaction");

   a_bad_range_fast: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command == sdh_pkg::CMD_QUERY &&
      req_data.left > req_data.right
      |=> rsp_valid && rsp_data.status == sdh_pkg::STATUS_BAD_RANGE)
      else $error("reversed range query not rejected in one cycle");

   a_start_new_len: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command == sdh_pkg::CMD_APPEND && req_data.start_new
      |=> rsp_valid && rsp_data.status == sdh_pkg::STATUS_OK &&
          rsp_data.stored_length == 13'd1)
      else $error("fresh string append did not report length one");

endmodule

bind substring_double_hash_unit sdh_checker u_sdh_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
